// ----- sv/orf_pkg.sv -----
package orf_pkg;

  localparam int WORD_W        = 32;
  localparam int CAP_W         = 7;
  localparam int OFF_W         = 6;
  localparam int CAP_RESET     = 64;
  localparam int CAP_LIMIT     = 2 ** CAP_W - 1;
  localparam int DEPTH_DEFAULT = 64;
  localparam int TREE_FANIN    = 8;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_PEEK = 1'b1
  } state_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [WORD_W-1:0]  data_in;
    logic        [OFF_W-1:0]   offset;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  data_out;
    logic                      valid_res;
    logic                      dropped_oldest;
    logic        [CAP_W-1:0]   count;
    logic        [CAP_W-1:0]   free_space;
  } out_item_t;

  typedef struct packed {
    logic                shift;
    logic                load;
    logic [CAP_W-1:0]    load_pos;
    logic [WORD_W-1:0]   wdata;
  } cell_ctl_t;

endpackage

// ----- sv/orf_cell.sv -----
module orf_cell
  import orf_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] up,
  output logic [WORD_W-1:0] q
);

  localparam bit               REACH = (POS <= CAP_LIMIT);
  localparam logic [CAP_W-1:0] POS_C = CAP_W'(POS);

  logic hit;

  assign hit = REACH && ctl.load && (ctl.load_pos == POS_C);

  always_ff @(posedge clk) begin
    if (hit) begin
      q <= ctl.wdata;
    end else if (ctl.shift) begin
      q <= up;
    end
  end

endmodule

// ----- sv/orf_tap_tree.sv -----
module orf_tap_tree
  import orf_pkg::*;
#(
  parameter int N = 64
) (
  input  logic              clk,
  input  logic              capture,
  input  logic [OFF_W-1:0]  off,
  input  logic [WORD_W-1:0] taps [N],
  output logic [WORD_W-1:0] sel
);

  localparam int NP = 2 ** OFF_W;
  localparam int GS = TREE_FANIN;
  localparam int NG = NP / GS;
  localparam int LW = $clog2(GS);

  logic [WORD_W-1:0]   padded [NG][GS];
  logic [WORD_W-1:0]   grp [NG];
  logic [OFF_W-LW-1:0] off_hi;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    for (genvar j = 0; j < GS; j++) begin : g_tap
      if (g * GS + j < N) begin : g_live
        assign padded[g][j] = taps[g * GS + j];
      end else begin : g_pad
        assign padded[g][j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int g = 0; g < NG; g++) begin
        grp[g] <= padded[g][off[LW-1:0]];
      end
      off_hi <= off[OFF_W-1:LW];
    end
  end

  assign sel = grp[off_hi];

endmodule

// ----- sv/overwriting_ring_fifo.sv -----
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data (mode, data_in, offset)
// out     | output    | out_valid / out_ready | out_data (data_out, valid_res, dropped_oldest,
//         |           |                       |           count, free_space)
// cfg     | input     | cfg_wr_en             | cfg_wr_data (capacity)
//
// Write, read and clear transactions go straight into the result register; a peek first
// passes the registered selection tree that picks the entry out of the cell row.
// The result register accepts a new transaction in the cycle its old result is taken.
// Reset empties the buffer and sets the capacity to 64; the entries themselves are not
// cleared. A stalled output holds the next transaction at the input.
module overwriting_ring_fifo
  import orf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int               PK      = (DEPTH < 2 ** OFF_W) ? DEPTH : 2 ** OFF_W;
  localparam int               CAP_TOP = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_TOP);
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'((CAP_RESET < CAP_TOP) ? CAP_RESET : CAP_TOP);

  state_t            state;
  state_t            state_next;
  logic [CAP_W-1:0]  fill;
  logic [CAP_W-1:0]  fill_next;
  logic [CAP_W-1:0]  cap_eff;
  logic              peek_hit;
  logic              acc;
  logic              full;
  logic              tree_capture;
  cell_ctl_t         ctl;
  out_item_t         imm_res;
  out_item_t         peek_res;
  logic [WORD_W-1:0] cell_q [DEPTH];
  logic [WORD_W-1:0] taps [PK];
  logic [WORD_W-1:0] tree_sel;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_mid
      orf_cell #(.POS(i)) u_cell (
        .clk (clk),
        .ctl (ctl),
        .up  (cell_q[i+1]),
        .q   (cell_q[i])
      );
    end else begin : g_end
      orf_cell #(.POS(i)) u_cell (
        .clk (clk),
        .ctl (ctl),
        .up  ('0),
        .q   (cell_q[i])
      );
    end
  end

  for (genvar k = 0; k < PK; k++) begin : g_tap
    assign taps[k] = cell_q[k];
  end

  orf_tap_tree #(.N(PK)) u_tree (
    .clk     (clk),
    .capture (tree_capture),
    .off     (in_data.offset),
    .taps    (taps),
    .sel     (tree_sel)
  );

  assign acc  = in_valid && in_ready;
  assign full = (fill == cap_eff);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && in_data.mode == MODE_PEEK) begin
          state_next = ST_PEEK;
        end
      end
      ST_PEEK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    tree_capture = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = !out_valid || out_ready;
        tree_capture = in_valid && (!out_valid || out_ready) && in_data.mode == MODE_PEEK;
      end
      ST_PEEK: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctl                    = '0;
    fill_next              = fill;
    imm_res                = '0;
    ctl.wdata              = in_data.data_in;
    case (in_data.mode)
      MODE_WRITE: begin
        ctl.load = acc;
        if (full) begin
          ctl.shift              = acc;
          ctl.load_pos           = cap_eff - CAP_W'(1);
          imm_res.dropped_oldest = 1'b1;
        end else begin
          ctl.load_pos = fill;
          fill_next    = fill + CAP_W'(1);
        end
      end
      MODE_READ: begin
        if (fill != '0) begin
          ctl.shift         = acc;
          imm_res.data_out  = cell_q[0];
          imm_res.valid_res = 1'b1;
          fill_next         = fill - CAP_W'(1);
        end
      end
      MODE_PEEK: begin
        fill_next = fill;
      end
      MODE_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        fill_next = fill;
      end
    endcase
    imm_res.count      = fill_next;
    imm_res.free_space = cap_eff - fill_next;
  end

  always_comb begin
    peek_res                = '0;
    peek_res.data_out       = peek_hit ? tree_sel : '0;
    peek_res.valid_res      = peek_hit;
    peek_res.count          = fill;
    peek_res.free_space     = cap_eff - fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      cap_eff   <= CAP_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        fill <= '0;
        if (cfg_wr_data == '0) begin
          cap_eff <= CAP_W'(1);
        end else if (cfg_wr_data > CAP_MAX) begin
          cap_eff <= CAP_MAX;
        end else begin
          cap_eff <= cfg_wr_data;
        end
      end else if (acc) begin
        fill <= fill_next;
      end
      if (acc && in_data.mode != MODE_PEEK) begin
        out_valid <= 1'b1;
      end else if (state == ST_PEEK) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      peek_hit <= ({1'b0, in_data.offset} < fill);
    end
    if (acc && in_data.mode != MODE_PEEK) begin
      out_data <= imm_res;
    end else if (state == ST_PEEK) begin
      out_data <= peek_res;
    end
  end

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill <= cap_eff)
    else $error("fill level above capacity");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    (acc && in_data.mode == MODE_WRITE && !full) |=>
      (out_valid && out_data.count == $past(fill) + CAP_W'(1)))
    else $error("write below capacity did not raise the count by one");

  a_peek_holds_output: assert property (@(posedge clk) disable iff (rst)
    (acc && in_data.mode == MODE_PEEK) |=> (state == ST_PEEK && !out_valid && !in_ready))
    else $error("peek transaction did not wait for the selection tree");

  a_peek_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PEEK) |=> (out_valid && out_data.count == $past(fill)))
    else $error("peek result missing or count changed");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
module tb
  import orf_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  in_item_t         in_data     = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  out_item_t        out_data;

  overwriting_ring_fifo dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [WORD_W-1:0] ring_words [DEPTH_DEFAULT];
  int unsigned       ring_head = 0;
  int unsigned       ring_tail = 0;
  int unsigned       ring_fill = 0;
  int unsigned       cap_reg   = CAP_RESET;

  out_item_t pending_results [$];

  int n_fail      = 0;
  int n_items     = 0;
  int n_results   = 0;
  int n_drops     = 0;
  int n_cfg       = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int rx_hold     = 0;
  int rx_style    = 0;
  bit gaps_on     = 1'b1;

  function automatic int unsigned used_capacity();
    int unsigned c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > DEPTH_DEFAULT) c = DEPTH_DEFAULT;
    return c;
  endfunction

  function automatic int unsigned wrap_inc(int unsigned p, int unsigned cap);
    return (p + 1 >= cap) ? 0 : p + 1;
  endfunction

  function automatic out_item_t fifo_apply(in_item_t it);
    int unsigned cap;
    int unsigned pos;
    out_item_t   r;
    cap = used_capacity();
    r = '0;
    case (it.mode)
      MODE_WRITE: begin
        if (ring_fill >= cap) begin
          ring_head = wrap_inc(ring_head, cap);
          ring_fill--;
          r.dropped_oldest = 1'b1;
        end
        ring_words[ring_tail] = it.data_in;
        ring_tail = wrap_inc(ring_tail, cap);
        ring_fill++;
      end
      MODE_READ: begin
        if (ring_fill != 0) begin
          r.data_out  = ring_words[ring_head];
          r.valid_res = 1'b1;
          ring_head   = wrap_inc(ring_head, cap);
          ring_fill--;
        end
      end
      MODE_PEEK: begin
        if (it.offset < ring_fill) begin
          pos = ring_head + it.offset;
          if (pos >= cap) pos = pos - cap;
          r.data_out  = ring_words[pos];
          r.valid_res = 1'b1;
        end
      end
      MODE_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
      end
      default: begin
        ring_fill = ring_fill;
      end
    endcase
    r.count      = CAP_W'(ring_fill);
    r.free_space = CAP_W'(cap - ring_fill);
    return r;
  endfunction

  function automatic in_item_t mk(mode_t m, logic [WORD_W-1:0] d, logic [OFF_W-1:0] o);
    in_item_t it;
    it.mode    = m;
    it.data_in = d;
    it.offset  = o;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    out_item_t r;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = fifo_apply(it);
    pending_results.push_back(r);
    n_items++;
    if (r.dropped_oldest) n_drops++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg   = value;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    n_cfg++;
  endtask

  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_hold  = $urandom_range(4, 40);
    end else begin
      rx_hold--;
    end
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin : check_result
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("Unexpected result at %0t: data_out=%h valid=%b dropped=%b count=%0d free=%0d",
                   $time, out_data.data_out, out_data.valid_res, out_data.dropped_oldest,
                   out_data.count, out_data.free_space);
      end else begin
        e = pending_results.pop_front();
        n_results++;
        if (out_data.data_out !== e.data_out || out_data.valid_res !== e.valid_res ||
            out_data.dropped_oldest !== e.dropped_oldest || out_data.count !== e.count ||
            out_data.free_space !== e.free_space) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("Mismatch at %0t: expected data_out=%h valid=%b dropped=%b count=%0d free=%0d",
                     $time, e.data_out, e.valid_res, e.dropped_oldest, e.count, e.free_space);
            $display("                 actual   data_out=%h valid=%b dropped=%b count=%0d free=%0d",
                     out_data.data_out, out_data.valid_res, out_data.dropped_oldest,
                     out_data.count, out_data.free_space);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_empty_after_reset();
    send_item(mk(MODE_READ, 32'h1234_5678, 6'd0));
    send_item(mk(MODE_PEEK, 32'h0, 6'd0));
    send_item(mk(MODE_PEEK, 32'hFFFF_FFFF, 6'd63));
    wait_for_results();
  endtask

  task automatic test_extreme_words();
    send_item(mk(MODE_WRITE, 32'h8000_0000, 6'd63));
    send_item(mk(MODE_WRITE, 32'h7FFF_FFFF, 6'd0));
    send_item(mk(MODE_WRITE, 32'hFFFF_FFFF, 6'd21));
    send_item(mk(MODE_WRITE, 32'h0000_0000, 6'd42));
    send_item(mk(MODE_PEEK, 32'h5555_5555, 6'd3));
    send_item(mk(MODE_PEEK, 32'hAAAA_AAAA, 6'd4));
    send_item(mk(MODE_READ, 32'h0, 6'd0));
    wait_for_results();
  endtask

  task automatic test_overflow_drop();
    set_capacity(7'd2);
    send_item(mk(MODE_WRITE, 32'h0000_0011, 6'd0));
    send_item(mk(MODE_WRITE, 32'h0000_0022, 6'd0));
    send_item(mk(MODE_WRITE, 32'h0000_0033, 6'd0));
    send_item(mk(MODE_READ, 32'h0, 6'd0));
    send_item(mk(MODE_READ, 32'h0, 6'd0));
    send_item(mk(MODE_READ, 32'h0, 6'd0));
    wait_for_results();
  endtask

  task automatic test_capacity_limits();
    set_capacity(7'd0);
    send_item(mk(MODE_WRITE, 32'hDEAD_BEEF, 6'd0));
    send_item(mk(MODE_WRITE, 32'hCAFE_F00D, 6'd0));
    send_item(mk(MODE_PEEK, 32'h0, 6'd0));
    set_capacity(7'd127);
    send_item(mk(MODE_WRITE, 32'h0BAD_C0DE, 6'd0));
    send_item(mk(MODE_PEEK, 32'h0, 6'd63));
    wait_for_results();
  endtask

  task automatic test_clear();
    send_item(mk(MODE_WRITE, 32'h1357_9BDF, 6'd0));
    send_item(mk(MODE_CLEAR, 32'hFFFF_FFFF, 6'd63));
    send_item(mk(MODE_READ, 32'h0, 6'd0));
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int          cap_plan [14];
    int          n_ops;
    int          roll;
    int          wlim;
    int          rlim;
    int          plim;
    mode_t       m;
    logic [31:0] d;
    logic [5:0]  o;
    cap_plan = '{1, 2, 64, 3, 4, 127, 7, 0, 8, 65, 16, 63, 31, $urandom_range(0, 127)};
    for (int ph = 0; ph < 14; ph++) begin
      set_capacity(cap_plan[ph][CAP_W-1:0]);
      n_ops   = (used_capacity() >= 32) ? 150 : 80;
      gaps_on = (ph % 4 != 3);
      if (ph % 2 == 0) begin
        wlim = 70; rlim = 82; plim = 99;
      end else begin
        wlim = 35; rlim = 70; plim = 97;
      end
      for (int k = 0; k < n_ops; k++) begin
        if (k == n_ops / 2) wait_for_results();
        roll = $urandom_range(0, 99);
        if (roll < wlim) m = MODE_WRITE;
        else if (roll < rlim) m = MODE_READ;
        else if (roll < plim) m = MODE_PEEK;
        else m = MODE_CLEAR;
        case ($urandom_range(0, 9))
          0: d = 32'h8000_0000;
          1: d = 32'h7FFF_FFFF;
          default: d = $urandom;
        endcase
        if (m == MODE_PEEK && $urandom_range(0, 9) < 7)
          o = (ring_fill > 63) ? 6'd63 : 6'($urandom_range(0, ring_fill));
        else
          o = 6'($urandom_range(0, 63));
        send_item(mk(m, d, o));
      end
    end
    gaps_on = 1'b1;
    wait_for_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_after_reset();
    test_extreme_words();
    test_overflow_drop();
    test_capacity_limits();
    test_clear();
    test_random_traffic();
    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d transactions over %0d capacity settings, %0d results checked.",
             n_items, n_cfg, n_results);
    $display("Writes that overwrote the oldest entry: %0d.", n_drops);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/orf_pkg.sv
sv/orf_cell.sv
sv/orf_tap_tree.sv
sv/overwriting_ring_fifo.sv
test/tb.sv
